/* hw/rtl/imh_pkg.sv */
// package for the indexed min-heap: sizes, status codes, operation kinds,
// transaction structs and the register map. no dependencies.
package imh_pkg;

  localparam int unsigned Capacity  = 256;
  localparam int unsigned IdSpace   = 1024;
  localparam int unsigned PosW      = $clog2(Capacity + 1);
  localparam int unsigned SlotW     = $clog2(Capacity);
  localparam int unsigned IdW       = $clog2(IdSpace);
  localparam int unsigned KeyW      = 32;
  localparam int unsigned PayW      = 32;
  localparam int unsigned HeapW     = KeyW + IdW + PayW;
  localparam int unsigned PaddrW    = 3;

  localparam logic [1:0] KindInsert  = 2'd0;
  localparam logic [1:0] KindSetKey  = 2'd1;
  localparam logic [1:0] KindDelMin  = 2'd2;
  localparam logic [1:0] KindRemove  = 2'd3;

  localparam logic [2:0] StatOk      = 3'd0;
  localparam logic [2:0] StatFull    = 3'd1;
  localparam logic [2:0] StatPresent = 3'd2;
  localparam logic [2:0] StatNoId    = 3'd3;
  localparam logic [2:0] StatEmpty   = 3'd4;

  localparam logic [PaddrW-1:0] AddrCapLimit = 3'd0;

  typedef struct packed {
    logic [1:0]             kind;
    logic [IdW-1:0]         entry_id;
    logic signed [KeyW-1:0] key_value;
    logic [PayW-1:0]        payload_in;
  } imh_req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [IdW-1:0]         out_id;
    logic signed [KeyW-1:0] out_key;
    logic [PayW-1:0]        out_payload;
  } imh_rsp_t;

endpackage

/* hw/rtl/indexed_min_heap.sv */
// Indexed binary min-heap. One transaction at a time: insert, set_key, delete_min or remove.
// Heap slots live in one ram (key, id, payload), the id-to-position table in another. A
// transaction passes through idle, a table read and a decision; delete_min and remove then
// fetch the entry and the last slot. Each level that an entry moves up takes a parent read,
// a compare and a write, and each level down takes two child reads, a compare and a write;
// a transaction also waits while its result is stalled. After reset the position table is
// cleared by a pass over every id, during which no transaction is accepted.
// depends on imh_pkg and imh_ram
module indexed_min_heap
  import imh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  imh_req_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output imh_rsp_t             out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [4:0] {
    StClear, StIdle, StPosWt, StDecide, StSlotWt, StSlotGot,
    StLastRd, StLastWt, StPlace, StUpRd, StUpWt, StDnRdL, StDnRdR, StDnWtR,
    StDnCmp, StFinal, StOut
  } state_e;

  state_e state_q;
  imh_req_t req_q;
  imh_rsp_t rsp_q;
  logic [8:0] cap_q;
  logic [PosW-1:0] count_q, cur_q, lim;
  logic [PosW-1:0] pos_q;
  logic [IdW-1:0] clr_q;
  logic cap_sel;
  // entry being moved
  logic [KeyW-1:0] mk_q, old_q;
  logic [IdW-1:0]  mi_q;
  logic [PayW-1:0] mp_q;
  logic [HeapW-1:0] ch_q;
  logic [PosW-1:0] chpos_q;
  logic up_q;

  // heap ram, slots 1..Capacity stored at address slot-1
  logic hp_we;
  logic [SlotW-1:0] hp_addr;
  logic [HeapW-1:0] hp_wd, hp_rd;
  // position ram
  logic ps_we;
  logic [IdW-1:0] ps_addr;
  logic [PosW-1:0] ps_wd, ps_rd;

  imh_ram #(.Width(HeapW), .Depth(Capacity)) u_heap (
    .clk_i, .we_i(hp_we), .addr_i(hp_addr), .wdata_i(hp_wd), .rdata_o(hp_rd));
  imh_ram #(.Width(PosW), .Depth(IdSpace)) u_pos (
    .clk_i, .we_i(ps_we), .addr_i(ps_addr), .wdata_i(ps_wd), .rdata_o(ps_rd));

  function automatic logic kless(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [SlotW-1:0] sa(logic [PosW-1:0] p);
    logic [PosW-1:0] t;
    t = p - 1'b1;
    return t[SlotW-1:0];
  endfunction

  logic [KeyW-1:0] rd_key;
  logic [IdW-1:0]  rd_id;
  logic [PayW-1:0] rd_pay;
  assign {rd_key, rd_id, rd_pay} = hp_rd;
  logic [KeyW-1:0] ch_key;
  assign ch_key = ch_q[HeapW-1 -: KeyW];

  assign lim = (cap_q > 9'(Capacity)) ? PosW'(Capacity) : PosW'(cap_q);

  // apb port, register index taken from the word address
  assign pready  = 1'b1;
  assign cap_sel = (paddr[PaddrW-1:2] == AddrCapLimit[PaddrW-1:2]);
  assign prdata  = cap_sel ? {23'd0, cap_q} : 32'd0;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = rsp_q;

  // memory control from state
  always_comb begin
    hp_we = 1'b0; hp_addr = sa(cur_q); hp_wd = {mk_q, mi_q, mp_q};
    ps_we = 1'b0; ps_addr = req_q.entry_id; ps_wd = cur_q;
    unique case (state_q)
      StClear: begin ps_we = 1'b1; ps_addr = clr_q; ps_wd = '0; end
      StIdle:  ps_addr = in_data_i.entry_id;
      StSlotWt: hp_addr = sa(pos_q);
      StLastRd: hp_addr = sa(count_q);
      StUpRd:  hp_addr = sa(cur_q >> 1);
      StDnRdL: hp_addr = sa({cur_q[PosW-2:0], 1'b0});
      StDnRdR: hp_addr = sa({cur_q[PosW-2:0], 1'b1});
      StPlace: begin
        // move child/parent entry into cur, update its table position
        hp_we = 1'b1; hp_wd = ch_q;
        ps_we = 1'b1; ps_addr = ch_q[PayW +: IdW]; ps_wd = cur_q;
      end
      StFinal: begin
        hp_we = 1'b1; ps_we = 1'b1; ps_addr = mi_q;
      end
      default: ;
    endcase
    // unmap the id taken out
    if (state_q == StLastWt) begin
      ps_we = 1'b1; ps_addr = req_q.kind == KindRemove ? req_q.entry_id : mi_q;
      ps_wd = '0;
    end
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; clr_q <= '0; count_q <= '0; cap_q <= 9'd256;
      req_q <= '0; rsp_q <= '0; cur_q <= '0; pos_q <= '0;
      mk_q <= '0; old_q <= '0; mi_q <= '0; mp_q <= '0;
      ch_q <= '0; chpos_q <= '0; up_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && cap_sel) cap_q <= pwdata[8:0];
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IdW'(IdSpace - 1)) state_q <= StIdle;
        end
        StIdle: if (in_valid_i) begin
          req_q <= in_data_i; state_q <= StPosWt;
          rsp_q <= '0;
        end
        StPosWt: begin pos_q <= ps_rd; state_q <= StDecide; end
        StDecide: begin
          unique case (req_q.kind)
            KindInsert: begin
              if (count_q >= lim) begin rsp_q.status <= StatFull; state_q <= StOut; end
              else if (pos_q != '0) begin rsp_q.status <= StatPresent; state_q <= StOut; end
              else begin
                count_q <= count_q + 1'b1; cur_q <= count_q + 1'b1;
                mk_q <= req_q.key_value; mi_q <= req_q.entry_id; mp_q <= req_q.payload_in;
                old_q <= req_q.key_value; up_q <= 1'b1; state_q <= StUpRd;
              end
            end
            KindDelMin: begin
              if (count_q == '0) begin rsp_q.status <= StatEmpty; state_q <= StOut; end
              else begin pos_q <= PosW'(1); state_q <= StSlotWt; end
            end
            default: begin
              if (pos_q == '0 || pos_q > count_q) begin
                rsp_q.status <= StatNoId; state_q <= StOut;
              end else state_q <= StSlotWt;
            end
          endcase
        end
        StSlotWt: state_q <= StSlotGot;
        StSlotGot: begin
          cur_q <= pos_q;
          if (req_q.kind == KindSetKey) begin
            mk_q <= req_q.key_value; mi_q <= rd_id; mp_q <= rd_pay; old_q <= rd_key;
            up_q <= kless(req_q.key_value, rd_key);
            state_q <= kless(req_q.key_value, rd_key) ? StUpRd : StDnRdL;
          end else begin
            rsp_q.out_id <= rd_id; rsp_q.out_key <= rd_key; rsp_q.out_payload <= rd_pay;
            old_q <= rd_key; mi_q <= rd_id;
            state_q <= StLastRd;
          end
        end
        StLastRd: state_q <= StLastWt;
        StLastWt: begin
          // last entry fills the hole, or the hole was the last slot
          count_q <= count_q - 1'b1;
          if (pos_q == count_q) state_q <= StOut;
          else begin
            mk_q <= rd_key; mi_q <= rd_id; mp_q <= rd_pay;
            up_q <= kless(rd_key, old_q);
            state_q <= kless(rd_key, old_q) ? StUpRd : StDnRdL;
          end
        end
        StUpRd: state_q <= (cur_q > PosW'(1)) ? StUpWt : StFinal;
        StUpWt: begin
          if (kless(mk_q, rd_key)) begin
            ch_q <= hp_rd; chpos_q <= cur_q >> 1; state_q <= StPlace;
          end else state_q <= StFinal;
        end
        StPlace: begin cur_q <= chpos_q; state_q <= up_q ? StUpRd : StDnRdL; end
        StDnRdL: state_q <= ({cur_q, 1'b0} <= {1'b0, count_q}) ? StDnRdR : StFinal;
        StDnRdR: begin
          ch_q <= hp_rd; chpos_q <= {cur_q[PosW-2:0], 1'b0};
          state_q <= ({cur_q, 1'b1} <= {1'b0, count_q}) ? StDnWtR : StDnCmp;
        end
        StDnWtR: begin
          if (kless(rd_key, ch_key)) begin
            ch_q <= hp_rd; chpos_q <= {cur_q[PosW-2:0], 1'b1};
          end
          state_q <= StDnCmp;
        end
        StDnCmp: state_q <= kless(ch_key, mk_q) ? StPlace : StFinal;
        StFinal: state_q <= StOut;
        StOut: if (!out_stall_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
      // ids out of range report not found before anything else
      if (state_q == StDecide && (32'(req_q.entry_id) >= IdSpace)
          && req_q.kind != KindDelMin) begin
        rsp_q.status <= StatNoId; state_q <= StOut;
      end
    end
  end

  // assertions
  a_count_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PosW'(Capacity)) else $error("entry count overflow");
  a_out_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StatOk) |-> out_data_o.out_key == '0)
    else $error("failed op returned data");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDecide && req_q.kind == KindInsert)
    |=> count_q >= $past(count_q)) else $error("insert shrank heap");

endmodule

/* hw/rtl/imh_ram.sv */
// generic single-port synchronous ram with a registered read
// no package dependencies
module imh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // registered read, a write returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
